// File: rtl/core/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants for the UTF-8 validator with a character limit.
// ----------------------------------------------------------------------------
package u8v_pkg;

	// Field widths.
	localparam int unsigned ByteW   = 8;
	localparam int unsigned MaxW    = 10;
	localparam int unsigned CountW  = 11;
	localparam int unsigned OutDataW = 16;
	localparam int unsigned AddrW   = 3;

	// Reset value of the character limit.
	localparam logic [MaxW-1:0] MaxCharsReset = 10'd64;

	// Register word index of the character limit.
	localparam logic RegMaxChars = 1'b0;

	// Byte values used by the lead and continuation checks.
	localparam logic [ByteW-1:0] AsciiMax  = 8'h7F;
	localparam logic [ByteW-1:0] Lead2Lo   = 8'hC2;
	localparam logic [ByteW-1:0] Lead2Hi   = 8'hDF;
	localparam logic [ByteW-1:0] Lead3Lo   = 8'hE0;
	localparam logic [ByteW-1:0] Lead3Hi   = 8'hEF;
	localparam logic [ByteW-1:0] Lead4Lo   = 8'hF0;
	localparam logic [ByteW-1:0] Lead4Hi   = 8'hF4;
	localparam logic [ByteW-1:0] LeadSurr  = 8'hED;
	localparam logic [ByteW-1:0] ContMask  = 8'hC0;
	localparam logic [ByteW-1:0] ContTag   = 8'h80;
	localparam logic [ByteW-1:0] ContA0    = 8'hA0;
	localparam logic [ByteW-1:0] Cont90    = 8'h90;
	localparam logic [ByteW-1:0] Terminator = 8'h00;

	// Range rule for the byte after a restricted lead byte.
	typedef enum logic [2:0] {
		RULE_NONE = 3'd0,
		RULE_E0   = 3'd1,
		RULE_ED   = 3'd2,
		RULE_F0   = 3'd3,
		RULE_F4   = 3'd4
	} rule_t;

	// One result word.
	typedef struct packed {
		logic [CountW-1:0] char_total;
		logic              is_valid;
	} result_t;

endpackage

// File: rtl/core/u8v_apb_regs.sv
// ----------------------------------------------------------------------------
// u8v_apb_regs
// APB register file holding the character limit.
// ----------------------------------------------------------------------------
module u8v_apb_regs
	import u8v_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [MaxW-1:0]  max_chars
);

	logic [MaxW-1:0] max_chars_q;
	logic            sel_max;

	// Word decode; the two low address bits select bytes and are ignored.
	assign sel_max = (paddr[AddrW-1] == RegMaxChars);
	assign pready  = 1'b1;

	// The limit register; writes to other words are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MaxCharsReset;
		end else if (psel && penable && pwrite && pready && sel_max) begin
			max_chars_q <= pwdata[MaxW-1:0];
		end
	end

	// Read back.
	assign prdata    = sel_max ? {{(32-MaxW){1'b0}}, max_chars_q} : 32'd0;
	assign max_chars = max_chars_q;

endmodule

// File: rtl/core/u8v_string_state.sv
// ----------------------------------------------------------------------------
// u8v_string_state
// Per-string decode state and its update for one byte.
// ----------------------------------------------------------------------------
module u8v_string_state
	import u8v_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [ByteW-1:0] text_byte,
	input  logic [MaxW-1:0]  max_chars,
	output result_t          result
);

	logic [1:0]        pending_q, pending_d;
	rule_t             rule_q, rule_d;
	logic [CountW-1:0] count_q, count_d;
	logic              fault_q, fault_d;

	logic [CountW-1:0] cap;
	logic [CountW-1:0] count_inc;
	logic              limit_hit;
	logic              cont_ok;
	logic              rule_ok;

	// Count one more character, saturating at the limit plus one.
	assign cap       = {1'b0, max_chars} + CountW'(1);
	assign count_inc = (count_q < cap) ? count_q + CountW'(1) : count_q;
	assign limit_hit = (count_inc > {1'b0, max_chars});

	// Continuation byte checks.
	always_comb begin
		case (rule_q)
			RULE_E0: rule_ok = (text_byte >= ContA0);
			RULE_ED: rule_ok = (text_byte <  ContA0);
			RULE_F0: rule_ok = (text_byte >= Cont90);
			RULE_F4: rule_ok = (text_byte <  Cont90);
			default: rule_ok = 1'b1;
		endcase
	end
	assign cont_ok = ((text_byte & ContMask) == ContTag) && rule_ok;

	// Result for a terminator byte, taken from the state before the update.
	assign result.is_valid   = !fault_q && (pending_q == 2'd0);
	assign result.char_total = count_q;

	// Next state for one byte.
	always_comb begin
		pending_d = pending_q;
		rule_d    = rule_q;
		count_d   = count_q;
		fault_d   = fault_q;
		if (text_byte == Terminator) begin
			pending_d = 2'd0;
			rule_d    = RULE_NONE;
			count_d   = '0;
			fault_d   = 1'b0;
		end else if (!fault_q) begin
			if (pending_q == 2'd0) begin
				if (text_byte <= AsciiMax) begin
					count_d = count_inc;
					fault_d = limit_hit;
				end else if (text_byte >= Lead2Lo && text_byte <= Lead2Hi) begin
					pending_d = 2'd1;
					rule_d    = RULE_NONE;
				end else if (text_byte >= Lead3Lo && text_byte <= Lead3Hi) begin
					pending_d = 2'd2;
					rule_d    = (text_byte == Lead3Lo) ? RULE_E0 :
					            (text_byte == LeadSurr) ? RULE_ED : RULE_NONE;
				end else if (text_byte >= Lead4Lo && text_byte <= Lead4Hi) begin
					pending_d = 2'd3;
					rule_d    = (text_byte == Lead4Lo) ? RULE_F0 :
					            (text_byte == Lead4Hi) ? RULE_F4 : RULE_NONE;
				end else begin
					fault_d = 1'b1;
				end
			end else if (!cont_ok) begin
				fault_d   = 1'b1;
				pending_d = 2'd0;
				rule_d    = RULE_NONE;
			end else begin
				rule_d    = RULE_NONE;
				pending_d = pending_q - 2'd1;
				if (pending_q == 2'd1) begin
					count_d = count_inc;
					fault_d = limit_hit;
				end
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			rule_q    <= RULE_NONE;
			count_q   <= '0;
			fault_q   <= 1'b0;
		end else if (advance) begin
			pending_q <= pending_d;
			rule_q    <= rule_d;
			count_q   <= count_d;
			fault_q   <= fault_d;
		end
	end

endmodule

// File: rtl/core/utf8_validate_with_char_limit.sv
// ----------------------------------------------------------------------------
// utf8_validate_with_char_limit
// Streaming UTF-8 validator that also limits the number of characters.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a NUL-terminated string arrive one word per cycle on the
//   s_ channel while s_tready is high. A byte of zero ends the string;
//   for it one result word leaves on the m_ channel: bit 0 is the valid
//   flag, bits 11:1 the character count saturated at the limit plus
//   one. Other bytes give no result. The limit is the register at APB
//   address 0 (10 bits, 64 after reset); the user must write it only
//   while the block is idle, and the block itself does not enforce this.
//   A byte is taken into an input register, decoded against the string
//   state from that register and, for a terminator, written to the output
//   register. One byte per cycle is accepted while s_tready is high.
//   When the receiver stalls, the output register holds its word and
//   ordinary bytes keep flowing; only a second terminator waits in the
//   input register, and s_tready falls once that register is blocked.
//   Reset clears the string state, both registers' valid flags and sets
//   the limit to 64.
// ----------------------------------------------------------------------------
module utf8_validate_with_char_limit
	import u8v_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Byte input; tdata: text_byte[7:0].
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ByteW-1:0]    s_tdata,
	// Result output; tdata: is_valid[0], char_total[11:1], zero pad[15:12].
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrW-1:0]    paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_valid_q;
	result_t          out_q;
	result_t          result;
	logic [MaxW-1:0]  max_chars;
	logic             is_term;
	logic             out_free;
	logic             advance;

	u8v_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_chars (max_chars)
	);

	// A terminator leaves the input register only when the output slot is free.
	assign is_term  = (byte_s1 == Terminator);
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!is_term || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	u8v_string_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.text_byte (byte_s1),
		.max_chars (max_chars),
		.result    (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && is_term;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_term) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW-CountW-1){1'b0}}, out_q};

endmodule

// File: rtl/core/u8v_checker.sv
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level checks for the UTF-8 validator.
// ----------------------------------------------------------------------------
module u8v_checker
	import u8v_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [ByteW-1:0]    s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [AddrW-1:0]    paddr,
	input logic [31:0]         pwdata,
	input logic [31:0]         prdata,
	input logic                pready
);

	// A byte word offered but not taken stays on the bus unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input word changed while waiting");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The padding above the count is zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OutDataW-1:CountW+1] == '0)
		else $error("result padding not zero");

	// The count never passes the largest limit plus one.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CountW:1] <= 11'd1024)
		else $error("character count out of range");

	// A limit write is read back on the next cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr == 3'd0 |=>
		(paddr != 3'd0) || prdata == {22'd0, $past(pwdata[MaxW-1:0])})
		else $error("limit register read back mismatch");

endmodule

bind utf8_validate_with_char_limit u8v_checker u_chk (.*);
